/* rtl/assert_macros.svh */
// assertion helpers used by the rtl top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

/* rtl/lcs_pkg.sv */
`default_nettype none

package lcs_pkg;

  // field widths
  localparam int ACTION_W = 3;
  localparam int VALUE_W  = 12;
  localparam int LEVEL_W  = 12;
  localparam int PCT_W    = 7;

  // default current width in milliamps
  localparam int CURRENT_BITS_DEF = 12;

  // reset values of the limits
  localparam int CEILING_RESET = 2000;
  localparam int FLOOR_RESET   = 100;

  // percent scale
  localparam int PCT_MAX   = 100;
  localparam int PCT_SCALE = 200;
  localparam int PCT_HALF  = 50;

  // command codes
  localparam logic [ACTION_W-1:0] ACT_SET_CURRENT = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_SET_PERCENT = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_SET_MAX     = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_SET_FLOOR   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_ENABLE      = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_DISABLE     = 3'd5;

endpackage

`default_nettype wire

/* rtl/lcs_cmd_if.sv */
`default_nettype none

interface lcs_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [lcs_pkg::ACTION_W-1:0] action;
  logic [lcs_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

`default_nettype wire

/* rtl/lcs_res_if.sv */
`default_nettype none

interface lcs_res_if;
  logic                        valid;
  logic                        ready;
  logic [lcs_pkg::LEVEL_W-1:0] drive_level;
  logic                        drive_write;
  logic                        drive_off;
  logic [lcs_pkg::LEVEL_W-1:0] setpoint_now;
  logic [lcs_pkg::PCT_W-1:0]   percent_now;
  logic                        on_now;

  modport source (output valid, output drive_level, output drive_write, output drive_off,
                  output setpoint_now, output percent_now, output on_now, input ready);
  modport sink   (input valid, input drive_level, input drive_write, input drive_off,
                  input setpoint_now, input percent_now, input on_now, output ready);
endinterface

`default_nettype wire

/* rtl/laser_current_setpoint_top.sv */
// laser diode current setpoint keeper
// cmd channel: one transaction per command (action, value); ready is high only while
//   the block is idle, so commands are handled one at a time
// res channel: one transaction per command with the driver action (drive_level,
//   drive_write, drive_off) and the stored setpoint, percent and enable flag after it
// timing: commands that need no division pass from acceptance through the prep and done
//   states into the output register; current/percent mapping adds a divide state that runs
//   a bit-serial restoring divider of CURRENT_BITS+9 steps
// pacing: the next command is taken the cycle after a result is loaded, so a command is
//   not taken before the previous one is done; the divider loop sets the pace
// reset: setpoint 0, maximum 2000 mA, threshold 100 mA, percent 0, driver disabled,
//   no result pending
// stall: a finished result sits in the output register; the next command may be taken
//   and worked on, but its result waits until the receiver takes the previous one
`default_nettype none

module laser_current_setpoint_top #(
  parameter int CURRENT_BITS = lcs_pkg::CURRENT_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  lcs_cmd_if.sink    cmd,
  lcs_res_if.source  res
);

  `include "assert_macros.svh"

  localparam int CB      = CURRENT_BITS;
  localparam int NUM_W   = CURRENT_BITS + 9;   // (a - floor) * 200 + r fits here
  localparam int DEN_W   = CURRENT_BITS + 1;   // 2 * r, and the constant 100
  localparam int VALUE_W = lcs_pkg::VALUE_W;
  localparam int LEVEL_W = lcs_pkg::LEVEL_W;
  localparam int PCT_W   = lcs_pkg::PCT_W;

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PREP = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  // follow-up work after the command is taken
  localparam logic [1:0] JOB_NONE = 2'd0;
  localparam logic [1:0] JOB_PCT  = 2'd1;   // percent from the setpoint
  localparam logic [1:0] JOB_AMPS = 2'd2;   // setpoint from the percent

  localparam logic [CB-1:0] CUR_MAX = {CB{1'b1}};

  logic [1:0]       state;
  logic [1:0]       job;

  // kept state
  logic [CB-1:0]    setpoint;
  logic [CB-1:0]    ceiling;
  logic [CB-1:0]    lasing_floor;
  logic [PCT_W-1:0] percent;
  logic             on_flag;

  // driver action of the command in flight
  logic             wr_flag;
  logic             off_flag;

  logic             out_valid;
  logic             out_load;

  // command decode
  logic [CB-1:0]    amps;
  logic [CB-1:0]    amps_clip;
  logic [CB-1:0]    set_amps;
  logic [PCT_W-1:0] pct_in;

  // divider hookup
  logic             div_start;
  logic             div_done;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic [NUM_W-1:0] div_quot;
  logic [CB-1:0]    span;
  logic [CB-1:0]    above;
  logic             falling;
  logic [NUM_W-1:0] prod;
  logic [PCT_W-1:0] pct_clamped;

  function automatic logic [VALUE_W-1:0] value_shift(input logic [VALUE_W-1:0] v);
    value_shift = v >> CURRENT_BITS;
  endfunction

  always_comb begin
    // saturate the raw value when the current width is narrower than the field
    amps      = ((value_shift(cmd.value)) != '0) ? CUR_MAX : CB'(cmd.value);
    amps_clip = (amps > ceiling) ? ceiling : amps;
    // nonzero currents below threshold snap to zero
    set_amps  = (amps_clip != '0 && amps_clip < lasing_floor) ? '0 : amps_clip;
    pct_in    = (cmd.value > VALUE_W'(lcs_pkg::PCT_MAX)) ? PCT_W'(lcs_pkg::PCT_MAX)
                                                         : PCT_W'(cmd.value);
  end

  // mapping operands, taken from the registers in the prep cycle
  always_comb begin
    falling = (ceiling < lasing_floor);
    span    = falling ? (lasing_floor - ceiling) : (ceiling - lasing_floor);
    above   = setpoint - lasing_floor;
    prod    = NUM_W'(percent) * NUM_W'(span);
    if (job == JOB_PCT) begin
      // ((a - floor) * 200 + r) / (2 * r), the times 200 as shifts
      div_num = (NUM_W'(above) << 7) + (NUM_W'(above) << 6) + (NUM_W'(above) << 3)
              + NUM_W'(span);
      div_den = DEN_W'(span) << 1;
    end else begin
      // (p * d + 50) / 100
      div_num = prod + NUM_W'(lcs_pkg::PCT_HALF);
      div_den = DEN_W'(lcs_pkg::PCT_MAX);
    end
    div_start = (state == S_PREP) &&
                (((job == JOB_PCT) && setpoint != '0 && ceiling > lasing_floor &&
                  setpoint >= lasing_floor) ||
                 ((job == JOB_AMPS) && percent != '0));
    // clamp the mapped percent to 1..100
    if (div_quot > NUM_W'(lcs_pkg::PCT_MAX)) begin
      pct_clamped = PCT_W'(lcs_pkg::PCT_MAX);
    end else if (div_quot == '0) begin
      pct_clamped = PCT_W'(1);
    end else begin
      pct_clamped = PCT_W'(div_quot);
    end
  end

  lcs_divider #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // result register can take the finished command when empty or being drained
  assign out_load  = (state == S_DONE) && (!out_valid || res.ready);
  assign cmd.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      job          <= JOB_NONE;
      setpoint     <= '0;
      ceiling      <= CB'(lcs_pkg::CEILING_RESET);
      lasing_floor <= CB'(lcs_pkg::FLOOR_RESET);
      percent      <= '0;
      on_flag      <= 1'b0;
      wr_flag      <= 1'b0;
      off_flag     <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            state    <= S_PREP;
            job      <= JOB_NONE;
            wr_flag  <= 1'b0;
            off_flag <= 1'b0;
            case (cmd.action)
              lcs_pkg::ACT_SET_CURRENT: begin
                setpoint <= set_amps;
                job      <= JOB_PCT;
                wr_flag  <= on_flag;
              end
              lcs_pkg::ACT_SET_PERCENT: begin
                percent <= pct_in;
                job     <= JOB_AMPS;
                wr_flag <= on_flag;
              end
              lcs_pkg::ACT_SET_MAX: begin
                ceiling <= amps;
                job     <= JOB_PCT;
                // a lowered maximum pulls the setpoint down with it
                if (setpoint > amps) begin
                  setpoint <= amps;
                  wr_flag  <= on_flag;
                end
              end
              lcs_pkg::ACT_SET_FLOOR: begin
                lasing_floor <= amps;
                // setpoint now under threshold: drop to zero and cut the driver if it is on
                if (setpoint != '0 && setpoint < amps) begin
                  setpoint <= '0;
                  percent  <= '0;
                  off_flag <= on_flag;
                end else begin
                  job <= JOB_PCT;
                end
              end
              lcs_pkg::ACT_ENABLE: begin
                on_flag <= 1'b1;
                wr_flag <= 1'b1;
              end
              lcs_pkg::ACT_DISABLE: begin
                on_flag  <= 1'b0;
                off_flag <= 1'b1;
              end
              default: begin
                // unused codes leave everything alone
              end
            endcase
          end
        end
        S_PREP: begin
          if (div_start) begin
            state <= S_DIV;
          end else begin
            state <= S_DONE;
            case (job)
              JOB_PCT: begin
                // zero current or empty range maps to zero, below threshold to one
                if (setpoint == '0 || ceiling <= lasing_floor) begin
                  percent <= '0;
                end else begin
                  percent <= PCT_W'(1);
                end
              end
              JOB_AMPS: begin
                setpoint <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_DONE;
            if (job == JOB_PCT) begin
              percent <= pct_clamped;
            end else begin
              // step goes from threshold toward the maximum in either direction
              setpoint <= falling ? (lasing_floor - CB'(div_quot))
                                  : (lasing_floor + CB'(div_quot));
            end
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res.drive_level  <= wr_flag ? LEVEL_W'(setpoint) : '0;
      res.drive_write  <= wr_flag;
      res.drive_off    <= off_flag;
      res.setpoint_now <= LEVEL_W'(setpoint);
      res.percent_now  <= percent;
      res.on_now       <= on_flag;
    end
  end

  assign res.valid = out_valid;

  // a taken command keeps the input closed for at least the next cycle
  `ASSERT_NEXT(a_busy_after_cmd, clk, rst, cmd.valid && cmd.ready, !cmd.ready, "input open after command")
  // a result never both writes a level and switches the driver off
  `ASSERT_IMPLIES(a_write_xor_off, clk, rst, res.valid, !(res.drive_write && res.drive_off), "write and off together")
  // reported percent stays within scale
  `ASSERT_IMPLIES(a_pct_range, clk, rst, res.valid, res.percent_now <= PCT_W'(lcs_pkg::PCT_MAX), "percent out of range")
  // the divider reports completion only while the sequencer waits for it
  `ASSERT_IMPLIES(a_div_in_state, clk, rst, div_done, state == S_DIV, "divider done outside divide state")

endmodule

`default_nettype wire

/* rtl/lcs_divider.sv */
`default_nettype none

// restoring divider, one quotient bit per cycle
module lcs_divider #(
  parameter int NUM_W = 21,
  parameter int DEN_W = 13
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [NUM_W-1:0]      quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] count;
  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] shreg;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_diff;
  logic             fits;

  // shift in the next dividend bit, try the subtract
  always_comb begin
    rem_sh   = {rem, shreg[NUM_W-1]};
    rem_diff = rem_sh - {1'b0, den};
    fits     = (rem_sh >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(NUM_W);
        rem   <= '0;
        shreg <= num;
      end else if (busy) begin
        rem   <= fits ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        shreg <= {shreg[NUM_W-2:0], fits};
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = shreg;

endmodule

`default_nettype wire

/* tb/sv/lcs_drive_checker.sv */
module lcs_drive_checker (
  input  wire logic   clk,
  input  wire logic   rst,
  lcs_cmd_if          cmd,
  lcs_res_if          res,
  output int unsigned mismatches,
  output int unsigned outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import lcs_pkg::*;

  typedef struct packed {
    logic [LEVEL_W-1:0] drive_level;
    logic               drive_write;
    logic               drive_off;
    logic [LEVEL_W-1:0] setpoint_now;
    logic [PCT_W-1:0]   percent_now;
    logic               on_now;
  } drive_report_t;

  // shadow copy of the setpoint keeper
  logic [LEVEL_W-1:0] setpoint_ma;
  logic [LEVEL_W-1:0] ceiling_ma;
  logic [LEVEL_W-1:0] floor_ma;
  logic [PCT_W-1:0]   pct_level;
  logic               laser_on;

  drive_report_t expected_reports[$];
  int unsigned   fail_total;

  // percent for a current, rounded half up, clamped to 1..100; zero current or an empty range gives 0
  function automatic logic [PCT_W-1:0] current_to_percent(input logic [LEVEL_W-1:0] amps);
    longint unsigned a64, c64, f64, span, q;
    a64 = amps;
    c64 = ceiling_ma;
    f64 = floor_ma;
    if (a64 == 0 || c64 <= f64) return '0;
    if (a64 < f64) return PCT_W'(1);
    span = c64 - f64;
    q = ((a64 - f64) * PCT_SCALE + span) / (2 * span);
    if (q < 1) q = 1;
    if (q > PCT_MAX) q = PCT_MAX;
    return q[PCT_W-1:0];
  endfunction

  // current for a percent, measured from the threshold toward the maximum
  function automatic logic [LEVEL_W-1:0] percent_to_current(input logic [PCT_W-1:0] pct);
    longint unsigned p64, c64, f64, step, amps;
    p64 = pct;
    c64 = ceiling_ma;
    f64 = floor_ma;
    if (p64 == 0) return '0;
    if (c64 >= f64) begin
      step = (p64 * (c64 - f64) + PCT_HALF) / PCT_MAX;
      amps = f64 + step;
    end else begin
      step = (p64 * (f64 - c64) + PCT_HALF) / PCT_MAX;
      amps = f64 - step;
    end
    return amps[LEVEL_W-1:0];
  endfunction

  function automatic void apply_command(input logic [ACTION_W-1:0] act,
                                        input logic [VALUE_W-1:0]  val);
    drive_report_t      rep;
    logic [LEVEL_W-1:0] amps;
    logic [PCT_W-1:0]   pct;
    rep  = '0;
    amps = val;
    pct  = (val > PCT_MAX) ? PCT_W'(PCT_MAX) : val[PCT_W-1:0];
    case (act)
      ACT_SET_CURRENT: begin
        if (amps > ceiling_ma) amps = ceiling_ma;
        if (amps != '0 && amps < floor_ma) amps = '0;
        setpoint_ma = amps;
        pct_level   = current_to_percent(amps);
        if (laser_on) begin
          rep.drive_write = 1'b1;
          rep.drive_level = setpoint_ma;
        end
      end
      ACT_SET_PERCENT: begin
        pct_level   = pct;
        setpoint_ma = percent_to_current(pct);
        if (laser_on) begin
          rep.drive_write = 1'b1;
          rep.drive_level = setpoint_ma;
        end
      end
      ACT_SET_MAX: begin
        ceiling_ma = amps;
        if (setpoint_ma > amps) begin
          setpoint_ma = amps;
          if (laser_on) begin
            rep.drive_write = 1'b1;
            rep.drive_level = setpoint_ma;
          end
        end
        pct_level = current_to_percent(setpoint_ma);
      end
      ACT_SET_FLOOR: begin
        floor_ma = amps;
        if (setpoint_ma != '0 && setpoint_ma < amps) begin
          setpoint_ma   = '0;
          pct_level     = '0;
          rep.drive_off = laser_on;
        end else begin
          pct_level = current_to_percent(setpoint_ma);
        end
      end
      ACT_ENABLE: begin
        laser_on        = 1'b1;
        rep.drive_write = 1'b1;
        rep.drive_level = setpoint_ma;
      end
      ACT_DISABLE: begin
        laser_on      = 1'b0;
        rep.drive_off = 1'b1;
      end
      default: begin
      end
    endcase
    rep.setpoint_now = setpoint_ma;
    rep.percent_now  = pct_level;
    rep.on_now       = laser_on;
    expected_reports.push_back(rep);
  endfunction

  task automatic check_field(input string field, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      fail_total++;
    end
  endtask

  always @(posedge clk) begin
    drive_report_t want;
    if (rst) begin
      setpoint_ma = '0;
      ceiling_ma  = LEVEL_W'(CEILING_RESET);
      floor_ma    = LEVEL_W'(FLOOR_RESET);
      pct_level   = '0;
      laser_on    = 1'b0;
      expected_reports.delete();
    end else begin
      // results leave only after their command is taken, so retire first
      if (res.valid && res.ready) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: result with nothing expected, expected none, actual level %0d",
                   $time, res.drive_level);
          fail_total++;
        end else begin
          want = expected_reports.pop_front();
          check_field("drive_level", 16'(want.drive_level), 16'(res.drive_level));
          check_field("drive_write", 16'(want.drive_write), 16'(res.drive_write));
          check_field("drive_off", 16'(want.drive_off), 16'(res.drive_off));
          check_field("setpoint_now", 16'(want.setpoint_now), 16'(res.setpoint_now));
          check_field("percent_now", 16'(want.percent_now), 16'(res.percent_now));
          check_field("on_now", 16'(want.on_now), 16'(res.on_now));
        end
      end
      if (cmd.valid && cmd.ready) apply_command(cmd.action, cmd.value);
    end
    mismatches  <= fail_total;
    outstanding <= $unsigned(expected_reports.size());
  end

endmodule

/* tb/sv/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lcs_pkg::*;

  // action codes the block has no use for, they must leave the state alone
  localparam logic [ACTION_W-1:0] ACT_SPARE_A = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_SPARE_B = 3'd7;

  localparam int SEGMENTS      = 7;    // random part, the last one without any idling
  localparam int SEGMENT_ITEMS = 100;
  localparam int LONG_HOLD     = 150;  // cycles the result side holds off once
  localparam int SETTLE        = 40;   // covers the longest mapping latency with margin
  localparam int LIMIT         = 400000;

  logic        clk = 1'b0;
  logic        rst;
  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned cycle_count;

  // idle probabilities in percent, changed per segment of the run
  int src_gap_pct  = 0;
  int sink_gap_pct = 0;
  bit sink_hold    = 1'b0;

  lcs_cmd_if cmd_ch ();
  lcs_res_if res_ch ();

  laser_current_setpoint_top DUT (
    .clk,
    .rst,
    .cmd (cmd_ch),
    .res (res_ch)
  );

  lcs_drive_checker drive_check (
    .clk,
    .rst,
    .cmd         (cmd_ch),
    .res         (res_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #1 clk = ~clk;

  // watchdog, a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("[laser_current_setpoint_top] ERROR");
      $finish;
    end
  end

  // offer one command and hold it until the block takes it; returns at the
  // accepting edge so the next command can follow back to back
  task automatic send_command(input logic [ACTION_W-1:0] act, input logic [VALUE_W-1:0] val);
    if ($urandom_range(1, 100) <= src_gap_pct) begin
      // idle burst, junk on the payload while valid is low
      cmd_ch.valid  <= 1'b0;
      cmd_ch.action <= ACTION_W'($urandom);
      cmd_ch.value  <= VALUE_W'($urandom);
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    cmd_ch.valid  <= 1'b1;
    cmd_ch.action <= act;
    cmd_ch.value  <= val;
    do @(posedge clk); while (!cmd_ch.ready);
  endtask

  // drop valid and wait until every transaction sent has produced its result
  task automatic wait_drained();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // result side: random ready bursts, one long hold-off on request
  initial begin
    res_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (sink_hold) begin
        // long stall so the block fills up and stops taking commands
        res_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        sink_hold = 1'b0;
      end else if ($urandom_range(1, 100) <= sink_gap_pct) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        res_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // command side: reset, directed corners, random segments, verdict
  initial begin
    int                  pick;
    logic [ACTION_W-1:0] act;
    logic [VALUE_W-1:0]  val;

    rst           <= 1'b1;
    cmd_ch.valid  <= 1'b0;
    cmd_ch.action <= '0;
    cmd_ch.value  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed corners with light idling on both sides
    src_gap_pct  = 30;
    sink_gap_pct = 30;
    send_command(ACT_SET_CURRENT, 12'd0);     // zero current while disabled
    send_command(ACT_ENABLE, 12'd0);          // enable writes the stored setpoint
    send_command(ACT_SET_CURRENT, 12'd4095);  // clamped to the maximum
    send_command(ACT_SET_CURRENT, 12'd50);    // below threshold snaps to zero
    send_command(ACT_SET_CURRENT, 12'd100);   // exactly at threshold, percent floors at 1
    send_command(ACT_SET_PERCENT, 12'd0);     // zero percent gives zero current
    send_command(ACT_SET_PERCENT, 12'd100);
    send_command(ACT_SET_PERCENT, 12'd4095);  // saturates at 100
    send_command(ACT_SET_PERCENT, 12'd50);
    send_command(ACT_SET_MAX, 12'd500);       // maximum below setpoint pulls it down
    send_command(ACT_SET_MAX, 12'd4095);
    send_command(ACT_SET_FLOOR, 12'd4095);    // threshold above setpoint turns the driver off
    send_command(ACT_SET_CURRENT, 12'd3000);  // below threshold again
    send_command(ACT_SET_PERCENT, 12'd37);    // maximum equal to threshold
    send_command(ACT_SET_MAX, 12'd0);         // maximum below threshold
    send_command(ACT_SET_PERCENT, 12'd60);    // mapping runs downward from threshold
    send_command(ACT_SET_FLOOR, 12'd0);
    send_command(ACT_SET_CURRENT, 12'd1);
    send_command(ACT_SET_MAX, 12'd2000);
    send_command(ACT_SET_FLOOR, 12'd100);
    send_command(ACT_SPARE_A, 12'd4095);      // unused codes report state unchanged
    send_command(ACT_SPARE_B, 12'd0);
    send_command(ACT_DISABLE, 12'd0);
    send_command(ACT_SET_CURRENT, 12'd1500);  // no driver write while disabled
    send_command(ACT_SET_FLOOR, 12'd2000);    // snap to zero, but no switch-off while disabled

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg == SEGMENTS - 1) begin
        // closing stretch at full rate on both sides
        src_gap_pct  = 0;
        sink_gap_pct = 0;
      end else begin
        src_gap_pct  = 25 * $urandom_range(0, 2);
        sink_gap_pct = 25 * $urandom_range(0, 2);
      end
      if (seg == 2) begin
        // keep offering while the result side is held off
        src_gap_pct = 0;
        sink_hold   = 1'b1;
      end
      // sender pauses until the block has answered everything
      if (seg == 3 || seg == 5) wait_drained();

      for (int k = 0; k < SEGMENT_ITEMS; k++) begin
        pick = $urandom_range(0, 99);
        val  = VALUE_W'($urandom);
        if (pick < 30) begin
          act = ACT_SET_CURRENT;
          if ($urandom_range(0, 3) != 0) val = VALUE_W'($urandom_range(0, 2500));
        end else if (pick < 55) begin
          act = ACT_SET_PERCENT;
          if ($urandom_range(0, 7) != 0) val = VALUE_W'($urandom_range(0, PCT_MAX));
        end else if (pick < 65) begin
          // mostly sane maximums, sometimes one under the threshold
          act = ACT_SET_MAX;
          if ($urandom_range(0, 4) == 0) val = VALUE_W'($urandom_range(0, 300));
          else                           val = VALUE_W'($urandom_range(800, 4095));
        end else if (pick < 75) begin
          act = ACT_SET_FLOOR;
          if ($urandom_range(0, 4) != 0) val = VALUE_W'($urandom_range(0, 400));
        end else if (pick < 84) begin
          act = ACT_ENABLE;
        end else if (pick < 92) begin
          act = ACT_DISABLE;
        end else begin
          act = pick[0] ? ACT_SPARE_A : ACT_SPARE_B;
        end
        send_command(act, val);
      end
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[laser_current_setpoint_top] OK");
    end else begin
      $display("[laser_current_setpoint_top] ERROR");
    end
    $finish;
  end

endmodule

/* laser_current_setpoint_top.f */
+incdir+rtl
rtl/lcs_pkg.sv
rtl/lcs_cmd_if.sv
rtl/lcs_res_if.sv
rtl/lcs_divider.sv
rtl/laser_current_setpoint_top.sv
tb/sv/lcs_drive_checker.sv
tb/sv/tb_top.sv
